FILE: src/filtered_message_slot_buffer_defines.svh
// Assertion macros shared by the checker of the filtered message slot buffer.
`ifndef FILTERED_MESSAGE_SLOT_BUFFER_DEFINES_SVH
`define FILTERED_MESSAGE_SLOT_BUFFER_DEFINES_SVH

// Property checked on every rising edge while reset is released.
`define FMSB_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("slot buffer assertion failed");

// Property checked on every rising edge, reset included.
`define FMSB_ASSERT_ALWAYS(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) prop) \
        else $error("slot buffer assertion failed");

`endif

FILE: src/fmsb_pkg.sv
// Types, codes and defaults shared by the filtered message slot buffer.
`timescale 1ns / 1ps

package fmsb_pkg;

    // Default sizes of the slot store.
    localparam int SLOTS_DEF         = 8;
    localparam int PAYLOAD_WIDTH_DEF = 32;

    // Operation codes carried in the func field.
    typedef enum logic [1:0] {
        FUNC_PUSH  = 2'd0,
        FUNC_POP   = 2'd1,
        FUNC_CLEAR = 2'd2
    } t_func;

    // System modes.
    typedef enum logic [1:0] {
        MODE_AUTODISC = 2'd0,
        MODE_LISTEN   = 2'd1,
        MODE_IDLE     = 2'd2,
        MODE_OTHER    = 2'd3
    } t_mode;

    // Sender role that the role filter rejects.
    localparam logic [1:0] ROLE_UNKNOWN = 2'd3;

    // Result status codes.
    typedef enum logic [2:0] {
        ST_STORED   = 3'd0,
        ST_MODE     = 3'd1,
        ST_DUP      = 3'd2,
        ST_ROUTED   = 3'd3,
        ST_FULL     = 3'd4,
        ST_POPPED   = 3'd5,
        ST_NOTFOUND = 3'd6,
        ST_CLEARED  = 3'd7
    } t_status;

    // Configuration register indexes.
    typedef enum logic [1:0] {
        CFG_DEDUP_ENABLE = 2'd0,
        CFG_ACCEPT_FIRST = 2'd1,
        CFG_ACCEPT_SECOND = 2'd2
    } t_cfg_index;

    // One input item.
    typedef struct packed {
        logic [1:0]  func;
        logic [7:0]  msg_type;
        logic [7:0]  node_id;
        logic [1:0]  node_type;
        logic        already_routed;
        logic [1:0]  system_mode;
        logic [31:0] payload;
    } t_in_item;

    // One result item.
    typedef struct packed {
        t_status     status;
        logic [7:0]  out_msg_type;
        logic [7:0]  out_node_id;
        logic [1:0]  out_node_type;
        logic [31:0] out_payload;
        logic [2:0]  out_slot;
    } t_out_item;

    // One configuration write.
    typedef struct packed {
        logic [1:0] reg_index;
        logic [7:0] wr_data;
    } t_cfg_wr;

    // Configuration register file.
    typedef struct packed {
        logic       dedup_enable;
        logic [7:0] accept_type_first;
        logic [7:0] accept_type_second;
    } t_cfg;

    // Searchable part of a stored slot.
    typedef struct packed {
        logic [7:0] msg_type;
        logic [7:0] node_id;
        logic [1:0] node_type;
    } t_key;

    // Slot store write request.
    typedef struct packed {
        logic en;
        t_key key;
    } t_mem_wr;

    // Outcome of comparing one slot against the current item.
    typedef struct packed {
        logic type_hit;
        logic dup_hit;
        logic free;
    } t_cmp;

endpackage

FILE: src/fmsb_chan_if.sv
// Valid/ready channel carrying one payload type.
`timescale 1ns / 1ps

interface fmsb_chan_if #(
    parameter type T = logic
);
    logic valid;
    logic ready;
    T     payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

FILE: src/fmsb_slot_mem.sv
// Slot store: one write port and one registered read port.
`timescale 1ns / 1ps

module fmsb_slot_mem #(
    parameter int SLOTS         = fmsb_pkg::SLOTS_DEF,
    parameter int PAYLOAD_WIDTH = fmsb_pkg::PAYLOAD_WIDTH_DEF,
    localparam int IDX_W        = (SLOTS > 1) ? $clog2(SLOTS) : 1
) (
    input  logic                     i_clk,
    input  fmsb_pkg::t_mem_wr        i_wr,
    input  logic [IDX_W-1:0]         i_wr_addr,
    input  logic [PAYLOAD_WIDTH-1:0] i_wr_payload,
    input  logic                     i_rd_en,
    input  logic [IDX_W-1:0]         i_rd_addr,
    output fmsb_pkg::t_key           o_rd_key,
    output logic [PAYLOAD_WIDTH-1:0] o_rd_payload
);

    fmsb_pkg::t_key           r_key_mem [SLOTS];
    logic [PAYLOAD_WIDTH-1:0] r_pay_mem [SLOTS];
    fmsb_pkg::t_key           r_rd_key;
    logic [PAYLOAD_WIDTH-1:0] r_rd_payload;

    // Write port.
    always_ff @(posedge i_clk) begin
        if (i_wr.en) begin
            r_key_mem[i_wr_addr] <= i_wr.key;
            r_pay_mem[i_wr_addr] <= i_wr_payload;
        end
    end

    // Registered read port.
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_key     <= r_key_mem[i_rd_addr];
            r_rd_payload <= r_pay_mem[i_rd_addr];
        end
    end

    assign o_rd_key     = r_rd_key;
    assign o_rd_payload = r_rd_payload;

endmodule

FILE: src/fmsb_cmp.sv
// Shared compare unit: checks one slot read from the store against the item.
`timescale 1ns / 1ps

module fmsb_cmp (
    input  logic           i_live,
    input  logic [7:0]     i_msg_type,
    input  logic [7:0]     i_node_id,
    input  fmsb_pkg::t_key i_ent,
    output fmsb_pkg::t_cmp o_cmp
);

    logic type_eq;
    logic node_eq;

    assign type_eq = (i_ent.msg_type == i_msg_type);
    assign node_eq = (i_ent.node_id == i_node_id);

    // A slot only counts when its valid bit is set.
    assign o_cmp.type_hit = i_live && type_eq;
    assign o_cmp.dup_hit  = i_live && type_eq && node_eq;
    assign o_cmp.free     = !i_live;

endmodule

FILE: src/fmsb_ctrl.sv
// Sequencer: filters items, scans the slots one per cycle and forms results.
`timescale 1ns / 1ps

module fmsb_ctrl #(
    parameter int SLOTS         = fmsb_pkg::SLOTS_DEF,
    parameter int PAYLOAD_WIDTH = fmsb_pkg::PAYLOAD_WIDTH_DEF,
    localparam int IDX_W        = (SLOTS > 1) ? $clog2(SLOTS) : 1
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    fmsb_chan_if.sink                i_in,
    fmsb_chan_if.source              o_out,
    input  fmsb_pkg::t_cfg           i_cfg,
    output fmsb_pkg::t_mem_wr        o_mem_wr,
    output logic [IDX_W-1:0]         o_wr_addr,
    output logic [PAYLOAD_WIDTH-1:0] o_wr_payload,
    output logic                     o_rd_en,
    output logic [IDX_W-1:0]         o_rd_addr,
    input  fmsb_pkg::t_key           i_rd_key,
    input  logic [PAYLOAD_WIDTH-1:0] i_rd_payload
);

    localparam int CNT_W = $clog2(SLOTS + 1);

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_DONE
    } t_state;

    t_state              r_state,      n_state;
    fmsb_pkg::t_in_item  r_item,       n_item;
    logic [SLOTS-1:0]    r_valid,      n_valid;
    logic [CNT_W-1:0]    r_cnt,        n_cnt;
    logic                r_cmp_vld,    n_cmp_vld;
    logic [IDX_W-1:0]    r_cmp_idx,    n_cmp_idx;
    logic                r_free_found, n_free_found;
    logic [IDX_W-1:0]    r_free_idx,   n_free_idx;
    fmsb_pkg::t_out_item r_res,        n_res;
    fmsb_pkg::t_out_item r_out,        n_out;
    logic                r_out_vld,    n_out_vld;

    fmsb_pkg::t_cmp   cmp;
    logic             in_xfer;
    logic             last_slot;
    logic             free_found;
    logic [IDX_W-1:0] free_idx;
    logic             mode_drop;
    logic             role_drop;

    // Compare the slot whose read data has just come back.
    fmsb_cmp u_cmp (
        .i_live     (r_valid[r_cmp_idx]),
        .i_msg_type (r_item.msg_type),
        .i_node_id  (r_item.node_id),
        .i_ent      (i_rd_key),
        .o_cmp      (cmp)
    );

    assign i_in.ready  = (r_state == S_IDLE);
    assign in_xfer     = i_in.valid && i_in.ready;
    assign o_out.valid = r_out_vld;
    assign o_out.payload = r_out;

    // Read address runs one slot ahead of the compare.
    assign o_rd_en   = (r_state == S_SCAN) && (r_cnt < CNT_W'(SLOTS));
    assign o_rd_addr = r_cnt[IDX_W-1:0];

    assign last_slot  = (r_cmp_idx == IDX_W'(SLOTS - 1));
    assign free_found = r_free_found || cmp.free;
    assign free_idx   = r_free_found ? r_free_idx : r_cmp_idx;

    assign o_wr_addr    = free_idx;
    assign o_wr_payload = PAYLOAD_WIDTH'(r_item.payload);

    // Mode filter on the arriving item.
    always_comb begin
        mode_drop = 1'b0;
        case (i_in.payload.system_mode)
            fmsb_pkg::MODE_AUTODISC, fmsb_pkg::MODE_LISTEN: begin
                mode_drop = (i_in.payload.msg_type != i_cfg.accept_type_first) &&
                            (i_in.payload.msg_type != i_cfg.accept_type_second);
            end
            fmsb_pkg::MODE_IDLE: begin
                mode_drop = 1'b1;
            end
            default: begin
                mode_drop = 1'b0;
            end
        endcase
    end

    // Role and routing filter on the held item.
    assign role_drop = i_cfg.dedup_enable &&
                       ((r_item.node_type == fmsb_pkg::ROLE_UNKNOWN) || r_item.already_routed);

    // Next-state logic of the sequencer.
    always_comb begin
        n_state      = r_state;
        n_item       = r_item;
        n_valid      = r_valid;
        n_cnt        = r_cnt;
        n_cmp_vld    = r_cmp_vld;
        n_cmp_idx    = r_cmp_idx;
        n_free_found = r_free_found;
        n_free_idx   = r_free_idx;
        n_res        = r_res;
        n_out        = r_out;
        n_out_vld    = r_out_vld;

        o_mem_wr.en  = 1'b0;
        o_mem_wr.key = '{msg_type: r_item.msg_type, node_id: r_item.node_id,
                         node_type: r_item.node_type};

        // The output register empties on a transfer.
        if (r_out_vld && o_out.ready) begin
            n_out_vld = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                if (in_xfer) begin
                    n_item       = i_in.payload;
                    n_cnt        = '0;
                    n_cmp_vld    = 1'b0;
                    n_free_found = 1'b0;
                    n_res        = '0;
                    n_res.status = fmsb_pkg::ST_NOTFOUND;
                    n_state      = S_DONE;
                    case (i_in.payload.func)
                        fmsb_pkg::FUNC_PUSH: begin
                            if (mode_drop) begin
                                n_res.status = fmsb_pkg::ST_MODE;
                            end else begin
                                n_state = S_SCAN;
                            end
                        end
                        fmsb_pkg::FUNC_POP: begin
                            n_state = S_SCAN;
                        end
                        fmsb_pkg::FUNC_CLEAR: begin
                            n_valid      = '0;
                            n_res.status = fmsb_pkg::ST_CLEARED;
                        end
                        default: begin
                            n_res.status = fmsb_pkg::ST_NOTFOUND;
                        end
                    endcase
                end
            end

            S_SCAN: begin
                n_cmp_vld = o_rd_en;
                n_cmp_idx = r_cnt[IDX_W-1:0];
                if (o_rd_en) begin
                    n_cnt = r_cnt + CNT_W'(1);
                end
                if (r_cmp_vld) begin
                    if (r_item.func == fmsb_pkg::FUNC_POP) begin
                        // Pop frees the lowest valid slot of the asked type.
                        if (cmp.type_hit) begin
                            n_valid[r_cmp_idx]  = 1'b0;
                            n_res.status        = fmsb_pkg::ST_POPPED;
                            n_res.out_msg_type  = i_rd_key.msg_type;
                            n_res.out_node_id   = i_rd_key.node_id;
                            n_res.out_node_type = i_rd_key.node_type;
                            n_res.out_payload   = 32'(i_rd_payload);
                            n_res.out_slot      = 3'(r_cmp_idx);
                            n_state             = S_DONE;
                        end else if (last_slot) begin
                            n_res.status = fmsb_pkg::ST_NOTFOUND;
                            n_state      = S_DONE;
                        end
                    end else if (i_cfg.dedup_enable && cmp.dup_hit) begin
                        n_res.status = fmsb_pkg::ST_DUP;
                        n_state      = S_DONE;
                    end else begin
                        // Remember the lowest free slot while scanning.
                        if (cmp.free && !r_free_found) begin
                            n_free_found = 1'b1;
                            n_free_idx   = r_cmp_idx;
                        end
                        if (last_slot) begin
                            n_state = S_DONE;
                            if (role_drop) begin
                                n_res.status = fmsb_pkg::ST_ROUTED;
                            end else if (free_found) begin
                                o_mem_wr.en       = 1'b1;
                                n_valid[free_idx] = 1'b1;
                                n_res.status      = fmsb_pkg::ST_STORED;
                                n_res.out_slot    = 3'(free_idx);
                            end else begin
                                n_res.status = fmsb_pkg::ST_FULL;
                            end
                        end
                    end
                end
            end

            S_DONE: begin
                // Hand the result over once the output register is free.
                if (!r_out_vld || o_out.ready) begin
                    n_out     = r_res;
                    n_out_vld = 1'b1;
                    n_state   = S_IDLE;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // State and registered outputs.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_valid   <= '0;
            r_cmp_vld <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_item       <= n_item;
            r_valid      <= n_valid;
            r_cnt        <= n_cnt;
            r_cmp_vld    <= n_cmp_vld;
            r_cmp_idx    <= n_cmp_idx;
            r_free_found <= n_free_found;
            r_free_idx   <= n_free_idx;
            r_res        <= n_res;
            r_out        <= n_out;
            r_out_vld    <= n_out_vld;
        end
    end

endmodule

FILE: src/filtered_message_slot_buffer.sv
// A push or a pop that misses scans every slot before the input is free again; the store's
// single registered read port gives one slot a cycle.
// A duplicate push or a pop that hits, found at slot k, ends the scan at that slot.
// A mode-filtered push, a clear or an unused code skips the scan; a held result adds its stall.
// The result becomes valid in the same cycle as the input becomes ready again.
// Synchronous active-low reset empties the buffer and loads the configuration defaults.
`timescale 1ns / 1ps

module filtered_message_slot_buffer #(
    parameter int SLOTS         = fmsb_pkg::SLOTS_DEF,
    parameter int PAYLOAD_WIDTH = fmsb_pkg::PAYLOAD_WIDTH_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    fmsb_chan_if.sink   i_in,
    fmsb_chan_if.source o_out,
    fmsb_chan_if.sink   i_cfg
);

    localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;

    fmsb_pkg::t_cfg           r_cfg;
    fmsb_pkg::t_mem_wr        mem_wr;
    logic [IDX_W-1:0]         wr_addr;
    logic [PAYLOAD_WIDTH-1:0] wr_payload;
    logic                     rd_en;
    logic [IDX_W-1:0]         rd_addr;
    fmsb_pkg::t_key           rd_key;
    logic [PAYLOAD_WIDTH-1:0] rd_payload;

    // Configuration writes are taken in every cycle.
    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.dedup_enable       <= 1'b1;
            r_cfg.accept_type_first  <= 8'd0;
            r_cfg.accept_type_second <= 8'd1;
        end else if (i_cfg.valid) begin
            case (i_cfg.payload.reg_index)
                fmsb_pkg::CFG_DEDUP_ENABLE: begin
                    r_cfg.dedup_enable <= i_cfg.payload.wr_data[0];
                end
                fmsb_pkg::CFG_ACCEPT_FIRST: begin
                    r_cfg.accept_type_first <= i_cfg.payload.wr_data;
                end
                fmsb_pkg::CFG_ACCEPT_SECOND: begin
                    r_cfg.accept_type_second <= i_cfg.payload.wr_data;
                end
                default: begin
                    r_cfg <= r_cfg;
                end
            endcase
        end
    end

    // Sequencer with the shared compare unit.
    fmsb_ctrl #(
        .SLOTS         (SLOTS),
        .PAYLOAD_WIDTH (PAYLOAD_WIDTH)
    ) u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in         (i_in),
        .o_out        (o_out),
        .i_cfg        (r_cfg),
        .o_mem_wr     (mem_wr),
        .o_wr_addr    (wr_addr),
        .o_wr_payload (wr_payload),
        .o_rd_en      (rd_en),
        .o_rd_addr    (rd_addr),
        .i_rd_key     (rd_key),
        .i_rd_payload (rd_payload)
    );

    // Slot contents.
    fmsb_slot_mem #(
        .SLOTS         (SLOTS),
        .PAYLOAD_WIDTH (PAYLOAD_WIDTH)
    ) u_mem (
        .i_clk        (i_clk),
        .i_wr         (mem_wr),
        .i_wr_addr    (wr_addr),
        .i_wr_payload (wr_payload),
        .i_rd_en      (rd_en),
        .i_rd_addr    (rd_addr),
        .o_rd_key     (rd_key),
        .o_rd_payload (rd_payload)
    );

endmodule

FILE: src/fmsb_checker.sv
// Port-level checks of the filtered message slot buffer, bound to the top level.
`timescale 1ns / 1ps
`include "filtered_message_slot_buffer_defines.svh"

module fmsb_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_valid,
    input logic        i_in_ready,
    input logic        i_out_valid,
    input logic        i_out_ready,
    input logic [2:0]  i_status,
    input logic [7:0]  i_out_msg_type,
    input logic [7:0]  i_out_node_id,
    input logic [1:0]  i_out_node_type,
    input logic [31:0] i_out_payload,
    input logic [2:0]  i_out_slot
);

    logic popped;
    logic slot_used;
    logic out_stall;
    logic in_xfer;
    logic fields_zero;

    assign popped      = (i_status == fmsb_pkg::ST_POPPED);
    assign slot_used   = popped || (i_status == fmsb_pkg::ST_STORED);
    assign out_stall   = i_out_valid && !i_out_ready;
    assign in_xfer     = i_in_valid && i_in_ready;
    assign fields_zero = (i_out_msg_type == 8'd0) && (i_out_node_id == 8'd0) &&
                         (i_out_node_type == 2'd0) && (i_out_payload == 32'd0);

    // A pending result holds until its transfer.
    `FMSB_ASSERT(a_out_hold, i_clk, i_rst_n, out_stall |=> i_out_valid && $stable(i_status))

    // The block works on one item at a time.
    `FMSB_ASSERT(a_busy_after_in, i_clk, i_rst_n, in_xfer |=> !i_in_ready)

    // Only a pop returns slot contents.
    `FMSB_ASSERT(a_fields_zero, i_clk, i_rst_n, i_out_valid && !popped |-> fields_zero)

    // A slot number is reported only for a store or a pop.
    `FMSB_ASSERT(a_slot_zero, i_clk, i_rst_n, i_out_valid && !slot_used |-> i_out_slot == 3'd0)

    // Reset leaves no result pending.
    `FMSB_ASSERT_ALWAYS(a_reset_out, i_clk, !i_rst_n |=> !i_out_valid)

endmodule

bind filtered_message_slot_buffer fmsb_checker u_fmsb_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_in_valid      (i_in.valid),
    .i_in_ready      (i_in.ready),
    .i_out_valid     (o_out.valid),
    .i_out_ready     (o_out.ready),
    .i_status        (o_out.payload.status),
    .i_out_msg_type  (o_out.payload.out_msg_type),
    .i_out_node_id   (o_out.payload.out_node_id),
    .i_out_node_type (o_out.payload.out_node_type),
    .i_out_payload   (o_out.payload.out_payload),
    .i_out_slot      (o_out.payload.out_slot)
);

FILE: tb/sv/fmsb_result_checker.sv
// Checker that predicts every result of the filtered message slot buffer and compares it.
`timescale 1ns / 1ps

module fmsb_result_checker
    import fmsb_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_msg_valid,
    input  logic      i_msg_ready,
    input  t_in_item  i_msg,
    input  logic      i_resp_valid,
    input  logic      i_resp_ready,
    input  t_out_item i_resp,
    input  logic      i_cfg_valid,
    input  logic      i_cfg_ready,
    input  t_cfg_wr   i_cfg,
    output int        o_pending,
    output int        o_fail_count
);

    localparam int SLOTS = SLOTS_DEF;

    // Register values after reset.
    localparam logic       DEDUP_AT_RESET         = 1'b1;
    localparam logic [7:0] ACCEPT_FIRST_AT_RESET  = 8'h00;
    localparam logic [7:0] ACCEPT_SECOND_AT_RESET = 8'h01;

    // Shadow copy of the configuration registers.
    logic       dedup_on;
    logic [7:0] accept_first;
    logic [7:0] accept_second;

    // Shadow copy of the slot store.
    logic [SLOTS-1:0] occupied;
    logic [7:0]       slot_msg_type  [SLOTS];
    logic [7:0]       slot_node_id   [SLOTS];
    logic [1:0]       slot_node_type [SLOTS];
    logic [31:0]      slot_payload   [SLOTS];

    // Results predicted but not yet seen on the output channel.
    t_out_item awaited_results [$];
    t_out_item oldest;
    int        failures      = 0;
    int        pending_count = 0;

    assign o_pending    = pending_count;
    assign o_fail_count = failures;

    // Works out the result of one message and updates the shadow store.
    function automatic t_out_item predict_response(input t_in_item msg);
        t_out_item resp;
        logic      duplicate;
        int        free_slot;
        int        hit_slot;
        resp        = '0;
        resp.status = ST_NOTFOUND;
        duplicate   = 1'b0;
        free_slot   = -1;
        hit_slot    = -1;
        // Scan downward so that the lowest matching or free slot wins.
        for (int s = SLOTS - 1; s >= 0; s--) begin
            if (!occupied[s]) begin
                free_slot = s;
            end
            if (occupied[s] && slot_msg_type[s] == msg.msg_type) begin
                hit_slot = s;
                if (slot_node_id[s] == msg.node_id) begin
                    duplicate = 1'b1;
                end
            end
        end
        case (msg.func)
            FUNC_PUSH: begin
                // Mode filter first, then duplicates, then role and routing.
                if (msg.system_mode == MODE_IDLE ||
                    ((msg.system_mode == MODE_AUTODISC || msg.system_mode == MODE_LISTEN) &&
                     msg.msg_type != accept_first && msg.msg_type != accept_second)) begin
                    resp.status = ST_MODE;
                end else if (dedup_on && duplicate) begin
                    resp.status = ST_DUP;
                end else if (dedup_on &&
                             (msg.node_type == ROLE_UNKNOWN || msg.already_routed)) begin
                    resp.status = ST_ROUTED;
                end else if (free_slot < 0) begin
                    resp.status = ST_FULL;
                end else begin
                    occupied[free_slot]       = 1'b1;
                    slot_msg_type[free_slot]  = msg.msg_type;
                    slot_node_id[free_slot]   = msg.node_id;
                    slot_node_type[free_slot] = msg.node_type;
                    slot_payload[free_slot]   = msg.payload;
                    resp.status               = ST_STORED;
                    resp.out_slot             = 3'(free_slot);
                end
            end
            FUNC_POP: begin
                if (hit_slot >= 0) begin
                    occupied[hit_slot] = 1'b0;
                    resp.status        = ST_POPPED;
                    resp.out_msg_type  = slot_msg_type[hit_slot];
                    resp.out_node_id   = slot_node_id[hit_slot];
                    resp.out_node_type = slot_node_type[hit_slot];
                    resp.out_payload   = slot_payload[hit_slot];
                    resp.out_slot      = 3'(hit_slot);
                end
            end
            FUNC_CLEAR: begin
                occupied    = '0;
                resp.status = ST_CLEARED;
            end
            // The unused code answers like a pop that finds nothing.
            default: ;
        endcase
        return resp;
    endfunction

    // Reports one field that differs from its prediction.
    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (got !== want) begin
            $error("%s: expected %0h, actual %0h", name, want, got);
            failures++;
        end
    endtask

    // Follow configuration writes, predict on each message transfer, check each result.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            dedup_on      = DEDUP_AT_RESET;
            accept_first  = ACCEPT_FIRST_AT_RESET;
            accept_second = ACCEPT_SECOND_AT_RESET;
            occupied      = '0;
            awaited_results.delete();
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg.reg_index)
                    CFG_DEDUP_ENABLE:  dedup_on = i_cfg.wr_data[0];
                    CFG_ACCEPT_FIRST:  accept_first = i_cfg.wr_data;
                    CFG_ACCEPT_SECOND: accept_second = i_cfg.wr_data;
                    default: ;
                endcase
            end
            if (i_msg_valid && i_msg_ready) begin
                awaited_results.push_back(predict_response(i_msg));
            end
            if (i_resp_valid && i_resp_ready) begin
                if (awaited_results.size() == 0) begin
                    $error("result transfer with none expected: status %0h", i_resp.status);
                    failures++;
                end else begin
                    oldest = awaited_results.pop_front();
                    check_field("status", 32'(oldest.status), 32'(i_resp.status));
                    check_field("out_msg_type", 32'(oldest.out_msg_type),
                                32'(i_resp.out_msg_type));
                    check_field("out_node_id", 32'(oldest.out_node_id),
                                32'(i_resp.out_node_id));
                    check_field("out_node_type", 32'(oldest.out_node_type),
                                32'(i_resp.out_node_type));
                    check_field("out_payload", oldest.out_payload, i_resp.out_payload);
                    check_field("out_slot", 32'(oldest.out_slot), 32'(i_resp.out_slot));
                end
            end
        end
        pending_count = awaited_results.size();
    end

endmodule

FILE: tb/sv/tb_filtered_message_slot_buffer.sv
// Top of the testbench: clock, reset, message and configuration stimulus, and the verdict.
`timescale 1ns / 1ps

module tb_filtered_message_slot_buffer;
    import fmsb_pkg::*;

    // The code that no operation uses.
    localparam logic [1:0] FUNC_UNUSED = 2'd3;

    // Sender roles that pass the role filter.
    localparam logic [1:0] ROLE_PROCESSOR = 2'd0;
    localparam logic [1:0] ROLE_PRODUCER  = 2'd1;
    localparam logic [1:0] ROLE_CONSUMER  = 2'd2;

    localparam int RESET_CYCLES = 8;
    localparam int PHASES       = 6;
    localparam int PHASE_ITEMS  = 305;
    // Wait at the end well past the longest push or pop.
    localparam int END_CYCLES   = 24;
    // Longest correct quiet stretch: the longest sender gap, the busy time of one item and the
    // longest receiver stall, plus the end wait. The limit is many times that.
    localparam int QUIET_LIMIT  = 1000;

    logic i_clk;
    logic i_rst_n;

    // Stimulus state shared by the driving processes.
    bit         idle_on;
    logic [7:0] cur_first;
    logic [7:0] cur_second;
    int         pending;
    int         fail_count;

    fmsb_chan_if #(.T(t_in_item))  msg_ch ();
    fmsb_chan_if #(.T(t_out_item)) resp_ch ();
    fmsb_chan_if #(.T(t_cfg_wr))   cfg_ch ();

    filtered_message_slot_buffer dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (msg_ch),
        .o_out   (resp_ch),
        .i_cfg   (cfg_ch)
    );

    fmsb_result_checker result_check (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_msg_valid  (msg_ch.valid),
        .i_msg_ready  (msg_ch.ready),
        .i_msg        (msg_ch.payload),
        .i_resp_valid (resp_ch.valid),
        .i_resp_ready (resp_ch.ready),
        .i_resp       (resp_ch.payload),
        .i_cfg_valid  (cfg_ch.valid),
        .i_cfg_ready  (cfg_ch.ready),
        .i_cfg        (cfg_ch.payload),
        .o_pending    (pending),
        .o_fail_count (fail_count)
    );

    // Free-running 8 ns clock.
    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    // Result receiver: ready drops in random bursts while idling is on.
    initial begin : receiver
        int stall_left;
        stall_left = 0;
        resp_ch.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (!idle_on) begin
                stall_left = 0;
            end else if (stall_left == 0 && $urandom_range(0, 5) == 0) begin
                stall_left = $urandom_range(1, 15);
            end
            if (stall_left > 0) begin
                resp_ch.ready <= 1'b0;
                stall_left--;
            end else begin
                resp_ch.ready <= 1'b1;
            end
        end
    end

    // Ends the run when no transfer of any kind happens for too long.
    initial begin : watchdog
        int quiet;
        quiet = 0;
        wait (i_rst_n === 1'b1);
        while (quiet < QUIET_LIMIT) begin
            @(posedge i_clk);
            if ((msg_ch.valid && msg_ch.ready) || (resp_ch.valid && resp_ch.ready) ||
                (cfg_ch.valid && cfg_ch.ready)) begin
                quiet = 0;
            end else begin
                quiet++;
            end
        end
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    function automatic t_in_item make_message(input logic [1:0] func,
                                              input logic [7:0] msg_type,
                                              input logic [7:0] node_id,
                                              input logic [1:0] node_type,
                                              input logic routed,
                                              input logic [1:0] mode,
                                              input logic [31:0] payload);
        t_in_item msg;
        msg.func           = func;
        msg.msg_type       = msg_type;
        msg.node_id        = node_id;
        msg.node_type      = node_type;
        msg.already_routed = routed;
        msg.system_mode    = mode;
        msg.payload        = payload;
        return msg;
    endfunction

    // Mostly messages that get past the mode filter, with node ids from a small
    // pool so that duplicates, full buffers and pop hits come up often.
    function automatic t_in_item random_message();
        t_in_item    msg;
        int unsigned pick;
        pick = $urandom_range(0, 99);
        if (pick < 58) begin
            msg.func = FUNC_PUSH;
        end else if (pick < 93) begin
            msg.func = FUNC_POP;
        end else if (pick < 97) begin
            msg.func = FUNC_CLEAR;
        end else begin
            msg.func = FUNC_UNUSED;
        end
        pick = $urandom_range(0, 99);
        if (pick < 35) begin
            msg.msg_type = cur_first;
        end else if (pick < 60) begin
            msg.msg_type = cur_second;
        end else if (pick < 85) begin
            msg.msg_type = 8'($urandom_range(0, 7));
        end else begin
            msg.msg_type = 8'($urandom_range(0, 255));
        end
        msg.node_id = ($urandom_range(0, 99) < 75) ? 8'($urandom_range(0, 7))
                                                   : 8'($urandom_range(0, 255));
        msg.node_type = ($urandom_range(0, 99) < 15) ? ROLE_UNKNOWN
                                                     : 2'($urandom_range(0, 2));
        msg.already_routed = ($urandom_range(0, 6) == 0);
        pick = $urandom_range(0, 99);
        if (pick < 40) begin
            msg.system_mode = MODE_OTHER;
        end else if (pick < 62) begin
            msg.system_mode = MODE_AUTODISC;
        end else if (pick < 84) begin
            msg.system_mode = MODE_LISTEN;
        end else begin
            msg.system_mode = MODE_IDLE;
        end
        msg.payload = $urandom;
        return msg;
    endfunction

    // One message transfer, after an optional random gap. Valid stays high
    // afterwards so that back-to-back messages need no second assignment.
    task automatic send_message(input t_in_item msg);
        if (idle_on && $urandom_range(0, 3) == 0) begin
            msg_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 15)) @(posedge i_clk);
        end
        msg_ch.valid   <= 1'b1;
        msg_ch.payload <= msg;
        do @(posedge i_clk); while (!msg_ch.ready);
    endtask

    // Holds off the sender until every predicted result has arrived.
    task automatic wait_for_results();
        msg_ch.valid <= 1'b0;
        @(posedge i_clk);
        wait (pending == 0);
        @(posedge i_clk);
    endtask

    // Writes all three registers, one transfer each.
    task automatic load_config(input logic dedup_val, input logic [7:0] type_a,
                               input logic [7:0] type_b);
        t_cfg_wr writes [3];
        writes[0].reg_index = CFG_DEDUP_ENABLE;
        writes[0].wr_data   = {7'd0, dedup_val};
        writes[1].reg_index = CFG_ACCEPT_FIRST;
        writes[1].wr_data   = type_a;
        writes[2].reg_index = CFG_ACCEPT_SECOND;
        writes[2].wr_data   = type_b;
        foreach (writes[k]) begin
            cfg_ch.valid   <= 1'b1;
            cfg_ch.payload <= writes[k];
            do @(posedge i_clk); while (!cfg_ch.ready);
        end
        cfg_ch.valid <= 1'b0;
        cur_first  = type_a;
        cur_second = type_b;
    endtask

    // Main sequence: reset, directed cases under reset values, then random phases.
    initial begin : stimulus
        msg_ch.valid   <= 1'b0;
        msg_ch.payload <= '0;
        cfg_ch.valid   <= 1'b0;
        cfg_ch.payload <= '0;
        i_rst_n        <= 1'b0;
        idle_on    = 1'b1;
        cur_first  = 8'h00;
        cur_second = 8'h01;
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Pop from an empty buffer, then stores under both accepted types.
        send_message(make_message(FUNC_POP, 8'h00, 8'h00, ROLE_PROCESSOR, 1'b0,
                                  MODE_OTHER, 32'h0000_0000));
        send_message(make_message(FUNC_PUSH, 8'h00, 8'h00, ROLE_PROCESSOR, 1'b0,
                                  MODE_AUTODISC, 32'h0000_0000));
        send_message(make_message(FUNC_PUSH, 8'h01, 8'hFF, ROLE_CONSUMER, 1'b0,
                                  MODE_LISTEN, 32'hFFFF_FFFF));
        // Mode filter: a type not accepted, and idle mode.
        send_message(make_message(FUNC_PUSH, 8'hFF, 8'h10, ROLE_PROCESSOR, 1'b0,
                                  MODE_AUTODISC, 32'h1234_5678));
        send_message(make_message(FUNC_PUSH, 8'h00, 8'h11, ROLE_PRODUCER, 1'b0,
                                  MODE_IDLE, 32'h8765_4321));
        // Any other mode passes every type.
        send_message(make_message(FUNC_PUSH, 8'h80, 8'h00, ROLE_PRODUCER, 1'b0,
                                  MODE_OTHER, 32'h8000_0001));
        // Duplicate of slot 0, then unknown role, then an already routed sender.
        send_message(make_message(FUNC_PUSH, 8'h00, 8'h00, ROLE_PROCESSOR, 1'b0,
                                  MODE_OTHER, 32'h5555_AAAA));
        send_message(make_message(FUNC_PUSH, 8'h05, 8'h07, ROLE_UNKNOWN, 1'b0,
                                  MODE_OTHER, 32'hAAAA_5555));
        send_message(make_message(FUNC_PUSH, 8'h06, 8'h07, ROLE_PRODUCER, 1'b1,
                                  MODE_OTHER, 32'h0F0F_F0F0));
        // Fill the remaining slots, then one push more finds the buffer full.
        for (int k = 0; k < 5; k++) begin
            send_message(make_message(FUNC_PUSH, 8'h20 + 8'(k), 8'h40 + 8'(k),
                                      ROLE_CONSUMER, 1'b0, MODE_OTHER, $urandom));
        end
        send_message(make_message(FUNC_PUSH, 8'h30, 8'h50, ROLE_PROCESSOR, 1'b0,
                                  MODE_OTHER, 32'hDEAD_0001));
        // Pops that hit, the unused code, a pop that misses, clear, pop after clear.
        send_message(make_message(FUNC_POP, 8'h80, 8'h00, ROLE_PROCESSOR, 1'b0,
                                  MODE_OTHER, 32'h0000_0000));
        send_message(make_message(FUNC_POP, 8'h01, 8'h00, ROLE_PROCESSOR, 1'b0,
                                  MODE_OTHER, 32'h0000_0000));
        send_message(make_message(FUNC_UNUSED, 8'h00, 8'h00, ROLE_PROCESSOR, 1'b0,
                                  MODE_OTHER, 32'h0000_0000));
        send_message(make_message(FUNC_POP, 8'h77, 8'h00, ROLE_PROCESSOR, 1'b0,
                                  MODE_OTHER, 32'h0000_0000));
        send_message(make_message(FUNC_CLEAR, 8'h00, 8'h00, ROLE_PROCESSOR, 1'b0,
                                  MODE_OTHER, 32'h0000_0000));
        send_message(make_message(FUNC_POP, 8'h00, 8'h00, ROLE_PROCESSOR, 1'b0,
                                  MODE_OTHER, 32'h0000_0000));
        wait_for_results();

        // Random phases, each under its own register setting.
        for (int phase = 0; phase < PHASES; phase++) begin
            case (phase)
                0: load_config(1'b1, 8'h00, 8'h01);
                1: load_config(1'b0, 8'hFF, 8'h00);
                2: load_config(1'b1, 8'hFF, 8'hFF);
                3: load_config(1'b0, 8'($urandom), 8'($urandom));
                4: load_config(1'b1, 8'($urandom), 8'($urandom));
                default: load_config(1'b1, 8'h00, 8'($urandom));
            endcase
            idle_on = (phase != 2) && (phase != PHASES - 1);
            repeat (PHASE_ITEMS) send_message(random_message());
            wait_for_results();
        end

        repeat (END_CYCLES) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule

FILE: files.f
+incdir+src
src/fmsb_pkg.sv
src/fmsb_chan_if.sv
src/fmsb_slot_mem.sv
src/fmsb_cmp.sv
src/fmsb_ctrl.sv
src/filtered_message_slot_buffer.sv
src/fmsb_checker.sv
tb/sv/fmsb_result_checker.sv
tb/sv/tb_filtered_message_slot_buffer.sv
